@@ hw/rtl/nct_pkg.sv @@
// Shared types and constants for the nonce challenge table.
`default_nettype none

package nct_pkg;

  // Fixed field widths
  localparam int NONCE_W = 64;
  localparam int TIME_W  = 48;
  localparam int TTL_W   = 47;
  localparam int SLOT_W  = 2;
  localparam int STAT_W  = 3;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic CFG_REG_TTL = 1'b0;   // register select bit paddr[3]

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(60000000);

  // Opcodes
  localparam logic OP_ISSUE  = 1'b0;
  localparam logic OP_VERIFY = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXPIRED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 3'd4;
  localparam logic [STAT_W-1:0] ST_SIG_BAD   = 3'd5;

  typedef struct packed {
    logic               opcode;
    logic [NONCE_W-1:0] nonce_value;
    logic [TIME_W-1:0]  now_time;
    logic               headers_ok;
    logic               request_too_long;
    logic               signature_ok;
  } item_in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_index;
  } item_out_t;

  // Lookup outcome from the slot table
  typedef struct packed {
    logic              found;
    logic              expired;
    logic [SLOT_W-1:0] hit_slot;
    logic [SLOT_W-1:0] issue_slot;
  } lookup_t;

endpackage

`default_nettype wire

@@ hw/rtl/nct_cfg_regs.sv @@
// APB-style configuration register block holding the challenge lifetime.
`default_nettype none

module nct_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [nct_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [nct_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic      [nct_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [nct_pkg::TTL_W-1:0]       ttl_time
);

  logic [nct_pkg::TTL_W-1:0] ttl_r;
  logic [nct_pkg::TTL_W-1:0] ttl_nxt;
  logic                      wr_en;
  logic                      sel_ttl;

  assign pready  = 1'b1;
  assign sel_ttl = (paddr[3] == nct_pkg::CFG_REG_TTL);
  assign wr_en   = psel && penable && pwrite && sel_ttl;

  // Lifetime register write
  always_comb begin
    ttl_nxt = ttl_r;
    if (wr_en) begin
      ttl_nxt = pwdata[nct_pkg::TTL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= nct_pkg::TTL_RESET;
    end else begin
      ttl_r <= ttl_nxt;
    end
  end

  // Read-back
  always_comb begin
    prdata = '0;
    if (sel_ttl) begin
      prdata = nct_pkg::CFG_DATA_W'(ttl_r);
    end
  end

  assign ttl_time = ttl_r;

endmodule

`default_nettype wire

@@ hw/rtl/nct_slot_table.sv @@
// Ring of challenge slots: parallel nonce match, age check and slot update.
`default_nettype none

module nct_slot_table #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire nct_pkg::item_in_t         item,
  input  wire logic                      fire,
  input  wire logic [nct_pkg::TTL_W-1:0] ttl_time,
  output nct_pkg::lookup_t               lookup
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic [SLOT_COUNT-1:0]      valid_r;
  logic [nct_pkg::NONCE_W-1:0] nonce_r [SLOT_COUNT];
  logic [nct_pkg::TIME_W-1:0]  time_r  [SLOT_COUNT];
  logic [IDX_W-1:0]           next_r;
  logic [IDX_W-1:0]           next_nxt;

  logic [SLOT_COUNT-1:0]      match;
  logic [IDX_W-1:0]           hit_idx;
  logic                       found;
  logic [nct_pkg::TIME_W-1:0] age;
  logic                       expired;
  logic                       do_issue;
  logic                       do_consume;

  // Parallel compare against every valid slot
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i] = valid_r[i] && (nonce_r[i] == item.nonce_value);
    end
  end

  // Lowest-numbered match wins
  always_comb begin
    hit_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign found   = |match;
  // Age wraps modulo the time width
  assign age     = item.now_time - time_r[hit_idx];
  assign expired = age > {1'b0, ttl_time};

  assign do_issue   = fire && (item.opcode == nct_pkg::OP_ISSUE);
  assign do_consume = fire && (item.opcode == nct_pkg::OP_VERIFY) && item.headers_ok &&
                      found && (expired || (!item.request_too_long && item.signature_ok));

  // Round-robin write pointer
  always_comb begin
    next_nxt = next_r;
    if (do_issue) begin
      next_nxt = (next_r == LAST_IDX) ? '0 : next_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      next_r  <= '0;
    end else begin
      next_r <= next_nxt;
      if (do_issue) begin
        valid_r[next_r] <= 1'b1;
      end else if (do_consume) begin
        valid_r[hit_idx] <= 1'b0;
      end
    end
  end

  // Slot payload, no reset
  always_ff @(posedge clk) begin
    if (do_issue) begin
      nonce_r[next_r] <= item.nonce_value;
      time_r[next_r]  <= item.now_time;
    end
  end

  assign lookup.found      = found;
  assign lookup.expired    = expired;
  assign lookup.hit_slot   = nct_pkg::SLOT_W'(hit_idx);
  assign lookup.issue_slot = nct_pkg::SLOT_W'(next_r);

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    next_r <= LAST_IDX)
    else $error("write pointer beyond slot count");

  a_issue_sets: assert property (@(posedge clk) disable iff (!rst_n)
    do_issue |=> valid_r[$past(next_r)])
    else $error("issued slot not marked valid");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    found |-> valid_r[hit_idx])
    else $error("match reported on an invalid slot");

  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    do_consume |=> !valid_r[$past(hit_idx)])
    else $error("consumed slot still valid");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/nonce_challenge_table_unit.sv @@
// Top level of the nonce challenge table: input stage, decision and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------
//  in_     | in        | in_valid/in_stall   | item_in_t in_data
//  out_    | out       | out_valid/out_stall | item_out_t out_data
//  cfg_    | in        | psel/penable/pready | ttl_time at byte 0
//
// One item per cycle while the result side is not stalled; each item is held in the input
// register while the slot table is searched, and its verdict is then written into the
// result register, which raises out_valid.
// Synchronous reset clears all valid flags, the slot marks and the write pointer.
// A stalled result holds the input register; a new item is still taken while
// the input register is empty.
`default_nettype none

module nonce_challenge_table_unit #(
  parameter int SLOT_COUNT = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire nct_pkg::item_in_t                   in_data,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output nct_pkg::item_out_t                       out_data,
  // configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [nct_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [nct_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [nct_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                     pready
);

  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  nct_pkg::item_in_t         s1_item_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  nct_pkg::item_out_t        out_data_r;
  nct_pkg::item_out_t        res;
  nct_pkg::lookup_t          lookup;
  logic [nct_pkg::TTL_W-1:0] ttl_time;
  logic                      advance;
  logic                      in_take;

  nct_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .ttl_time (ttl_time)
  );

  nct_slot_table #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (s1_item_r),
    .fire     (advance),
    .ttl_time (ttl_time),
    .lookup   (lookup)
  );

  // Handshake control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Result decision: issue slot, or verify checks in priority order
  always_comb begin
    res.status     = nct_pkg::ST_OK;
    res.slot_index = '0;
    if (s1_item_r.opcode == nct_pkg::OP_ISSUE) begin
      res.slot_index = lookup.issue_slot;
    end else if (!s1_item_r.headers_ok) begin
      res.status = nct_pkg::ST_MALFORMED;
    end else if (!lookup.found) begin
      res.status = nct_pkg::ST_UNKNOWN;
    end else begin
      res.slot_index = lookup.hit_slot;
      if (lookup.expired) begin
        res.status = nct_pkg::ST_EXPIRED;
      end else if (s1_item_r.request_too_long) begin
        res.status = nct_pkg::ST_TOO_LONG;
      end else if (!s1_item_r.signature_ok) begin
        res.status = nct_pkg::ST_SIG_BAD;
      end
    end
  end

  // Stage valid flags
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with no item held");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.status <= nct_pkg::ST_SIG_BAD)
    else $error("result status out of range");

  a_issue_ok: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_item_r.opcode == nct_pkg::OP_ISSUE |=> out_data_r.status == nct_pkg::ST_OK)
    else $error("issue returned a failure status");
`endif

endmodule

`default_nettype wire

@@ tb/nct_checker.sv @@
// Checker for the nonce challenge table: mirrors the slot ring and compares every verdict.
module nct_checker
  import nct_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire item_in_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire item_out_t             out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  input  wire logic [CFG_DATA_W-1:0] prdata,
  input  wire logic                  pready,
  output int                         mismatches,
  output int                         verdicts_open,
  output int                         requests_seen,
  output int                         verdicts_checked,
  output logic [5:0]                 status_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the slot ring and the lifetime register
  logic [TTL_W-1:0]   ttl_q;
  logic [3:0]         slot_live;
  logic [NONCE_W-1:0] slot_nonce_q [4];
  logic [TIME_W-1:0]  slot_time_q [4];
  logic [SLOT_W-1:0]  issue_ptr;

  // Verdicts awaited, oldest first
  item_out_t verdict_q [$];

  int err_n;
  int req_n;
  int chk_n;
  logic [5:0] seen_n;

  // Works out the verdict of one request and updates the mirrored ring
  function automatic item_out_t judge_request(input item_in_t req);
    item_out_t v;
    logic [TIME_W-1:0] age;
    int hit;
    v.status     = ST_OK;
    v.slot_index = '0;
    hit          = -1;
    if (req.opcode == OP_ISSUE) begin
      slot_live[issue_ptr]    = 1'b1;
      slot_nonce_q[issue_ptr] = req.nonce_value;
      slot_time_q[issue_ptr]  = req.now_time;
      v.slot_index            = issue_ptr;
      issue_ptr               = issue_ptr + 1'b1;
    end else if (!req.headers_ok) begin
      v.status = ST_MALFORMED;
    end else begin
      // lowest-numbered live slot wins
      for (int i = 3; i >= 0; i--) begin
        if (slot_live[i] && slot_nonce_q[i] == req.nonce_value) hit = i;
      end
      if (hit < 0) begin
        v.status = ST_UNKNOWN;
      end else begin
        v.slot_index = SLOT_W'(hit);
        age = req.now_time - slot_time_q[hit];   // wraps at the time width
        if (age > TIME_W'(ttl_q)) begin
          v.status       = ST_EXPIRED;
          slot_live[hit] = 1'b0;
        end else if (req.request_too_long) begin
          v.status = ST_TOO_LONG;
        end else if (!req.signature_ok) begin
          v.status = ST_SIG_BAD;
        end else begin
          slot_live[hit] = 1'b0;
        end
      end
    end
    return v;
  endfunction

  always @(posedge clk) begin
    item_out_t want;
    if (!rst_n) begin
      ttl_q     = TTL_RESET;
      slot_live = '0;
      issue_ptr = '0;
      for (int i = 0; i < 4; i++) begin
        slot_nonce_q[i] = '0;
        slot_time_q[i]  = '0;
      end
      verdict_q.delete();
      err_n  = 0;
      req_n  = 0;
      chk_n  = 0;
      seen_n = '0;
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr[CFG_ADDR_W-1] == CFG_REG_TTL) begin
        if (pwrite) begin
          ttl_q = pwdata[TTL_W-1:0];
        end else if (prdata !== CFG_DATA_W'(ttl_q)) begin
          $error("ttl_time: expected %0h, actual %0h", ttl_q, prdata);
          err_n++;
        end
      end

      // result side
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with no request outstanding: status %0d slot %0d",
                 out_data.status, out_data.slot_index);
          err_n++;
        end else begin
          want = verdict_q.pop_front();
          chk_n++;
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            err_n++;
          end
          if (out_data.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d",
                   want.slot_index, out_data.slot_index);
            err_n++;
          end
          if (out_data.status < 3'd6) seen_n[out_data.status] = 1'b1;
        end
      end

      // request side
      if (in_valid && !in_stall) begin
        verdict_q.push_back(judge_request(in_data));
        req_n++;
      end
    end
    mismatches       <= err_n;
    verdicts_open    <= verdict_q.size();
    requests_seen    <= req_n;
    verdicts_checked <= chk_n;
    status_seen      <= seen_n;
  end

endmodule

@@ tb/tb_nonce_challenge_table_unit.sv @@
// Testbench top for the nonce challenge table: stimulus, register setup and verdict.
module tb_nonce_challenge_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import nct_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TTL   = {CFG_REG_TTL, 3'b000};
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = {~CFG_REG_TTL, 3'b000};
  localparam logic [TTL_W-1:0]      TTL_MAX    = {TTL_W{1'b1}};
  localparam logic [TIME_W-1:0]     T_NEAR_WRAP = 48'hFFFF_FFFF_F000;
  localparam int                    QUIET_LIMIT = 1000;
  localparam int                    SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  item_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  item_out_t             out_data;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int         mismatches;
  int         verdicts_open;
  int         requests_seen;
  int         verdicts_checked;
  logic [5:0] status_seen;

  int                 idle_pct = 11;
  int                 quiet_cycles = 0;
  int                 ttl_settings = 1;
  logic [TIME_W-1:0]  clock_now = 48'd1000;
  logic [NONCE_W-1:0] recent_nonce [4] = '{default: '0};
  logic [1:0]         recent_ptr = '0;

  nonce_challenge_table_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nct_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .mismatches, .verdicts_open, .requests_seen, .verdicts_checked, .status_seen
  );

  always #2 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < idle_pct);

  // watchdog on cycles without any progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_in_t mk_req(input logic op, input logic [NONCE_W-1:0] nonce,
                                      input logic [TIME_W-1:0] t, input logic hdr,
                                      input logic too_long, input logic sig);
    item_in_t r;
    r.opcode           = op;
    r.nonce_value      = nonce;
    r.now_time         = t;
    r.headers_ok       = hdr;
    r.request_too_long = too_long;
    r.signature_ok     = sig;
    return r;
  endfunction

  // Offers one item, with a random idle gap ahead of it, and waits for acceptance
  task automatic send_request(input item_in_t req);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits for every outstanding verdict
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_open != 0) @(posedge clk);
  endtask

  // One register access: setup cycle, access cycle, then release
  task automatic reg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ttl(input logic [TTL_W-1:0] ttl, input logic [16:0] junk);
    reg_access(1'b1, ADDR_TTL, {junk, ttl});
    reg_access(1'b0, ADDR_TTL, '0);
    ttl_settings++;
  endtask

  // Random traffic: mostly issue/verify pairs on recent nonces, some noise
  task automatic run_traffic(input int count, input logic [TIME_W-1:0] step,
                             input int pause_at);
    item_in_t req;
    logic [63:0] r64;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain();
      r64 = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 3) clock_now = r64[TIME_W-1:0];
      else clock_now = clock_now + TIME_W'(r64 % ({16'b0, step} + 64'd1));
      req = mk_req(OP_VERIFY, '0, clock_now, $urandom_range(0, 99) < 92,
                   $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 85);
      pick = $urandom_range(0, 99);
      r64  = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 40) begin
        req.opcode = OP_ISSUE;
        // a few issues repeat a nonce already in the ring
        req.nonce_value = (pick < 15) ? recent_nonce[$urandom_range(0, 3)] : r64;
        recent_nonce[recent_ptr] = req.nonce_value;
        recent_ptr = recent_ptr + 1'b1;
      end else if (pick < 80) begin
        req.nonce_value = recent_nonce[$urandom_range(0, 3)];
      end else if (pick < 90) begin
        req.nonce_value = r64;
      end else begin
        // near miss: one bit off a recent nonce
        req.nonce_value = recent_nonce[$urandom_range(0, 3)] ^ (64'd1 << $urandom_range(0, 63));
      end
      send_request(req);
    end
    drain();
  endtask

  initial begin
    logic [63:0] r64;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the lifetime register
    reg_access(1'b0, ADDR_TTL, '0);

    // Directed: empty table, extremes, every status, boundaries and ring wrap
    send_request(mk_req(OP_VERIFY, 64'd0, 48'd0, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, 64'd0, T_NEAR_WRAP, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, '1, 48'd0, 1'b0, 1'b1, 1'b0));
    send_request(mk_req(OP_VERIFY, 64'd0, T_NEAR_WRAP, 1'b0, 1'b0, 1'b1));
    send_request(mk_req(OP_VERIFY, 64'd123, T_NEAR_WRAP, 1'b1, 1'b0, 1'b1));
    // age equal to the lifetime, across the time wrap: still live
    send_request(mk_req(OP_VERIFY, 64'd0, T_NEAR_WRAP + TIME_W'(TTL_RESET), 1'b1, 1'b1, 1'b1));
    send_request(mk_req(OP_VERIFY, 64'd0, T_NEAR_WRAP + TIME_W'(TTL_RESET), 1'b1, 1'b0, 1'b0));
    // one past the lifetime: expired and dropped
    send_request(mk_req(OP_VERIFY, 64'd0, T_NEAR_WRAP + TIME_W'(TTL_RESET) + 48'd1,
                        1'b1, 1'b1, 1'b0));
    send_request(mk_req(OP_VERIFY, 64'd0, T_NEAR_WRAP, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_VERIFY, '1, 48'd5, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_VERIFY, '1, 48'd6, 1'b1, 1'b0, 1'b1));
    // duplicate nonce in two slots, then overwrite of a live slot
    send_request(mk_req(OP_ISSUE, 64'hA5A5_0000_0000_00A5, 48'd100, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, 64'hA5A5_0000_0000_00A5, 48'd200, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, 64'h0123_4567_89AB_CDEF, '1, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, 64'hFEDC_BA98_7654_3210, 48'd250, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_ISSUE, 64'h5A5A_5A5A_5A5A_5A5A, 48'd260, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_VERIFY, 64'hA5A5_0000_0000_00A5, 48'd300, 1'b1, 1'b0, 1'b1));
    send_request(mk_req(OP_VERIFY, 64'h0123_4567_89AB_CDEF, 48'd10, 1'b1, 1'b0, 1'b1));
    drain();

    // zero lifetime: any elapsed time expires
    set_ttl('0, '0);
    run_traffic(300, 48'd3, -1);

    // widest lifetime, ages spread over the whole time range
    set_ttl(TTL_MAX, '1);
    run_traffic(350, 48'h3000_0000_0000, 175);

    // short lifetime, no idling on either side
    idle_pct = 0;
    set_ttl(47'd50, '0);
    run_traffic(350, 48'd25, -1);
    idle_pct = 11;

    // random lifetime; a write to the unused register must change nothing
    r64 = {$urandom, $urandom};
    set_ttl(r64[TTL_W-1:0], r64[63:47]);
    r64 = {$urandom, $urandom};
    reg_access(1'b1, ADDR_SPARE, r64);
    reg_access(1'b0, ADDR_TTL, '0);
    run_traffic(400, TIME_W'(r64[TTL_W-1:0] / 3) + 48'd1, -1);

    // back to the power-on lifetime
    set_ttl(TTL_RESET, '0);
    run_traffic(450, 48'd15000000, -1);

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked verdicts over %0d lifetime settings.",
             requests_seen, verdicts_checked, ttl_settings);
    $display("Verdict codes observed (one bit per status, ok at bit 0): %b", status_seen);
    if (mismatches == 0 && verdicts_open == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
